// ----- hdl/sicxe_instruction_decoder_defines.svh -----
// assertion macros shared by the sic/xe decoder rtl
`ifndef SICXE_INSTRUCTION_DECODER_DEFINES_SVH
`define SICXE_INSTRUCTION_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SXD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SXD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sxd_pkg.sv -----
// types, constants and opcode table of the sic/xe decoder
`timescale 1ns / 1ps
`default_nettype none

package sxd_pkg;

    localparam int ADDR_WIDTH_DEF = 20;
    localparam int PORT_ADDR_W    = 20;
    localparam int TABLE_SIZE     = 59;
    localparam int IDX_W          = 6;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_TDATA_W    = 96;

    localparam logic [7:0] OP_LDB  = 8'h68;
    localparam logic [7:0] OP_MASK = 8'hFC;

    localparam logic [2:0] FMT_1 = 3'd1;
    localparam logic [2:0] FMT_2 = 3'd2;
    localparam logic [2:0] FMT_3 = 3'd3;
    localparam logic [2:0] FMT_4 = 3'd4;

    localparam logic [1:0] MODE_SIMPLE = 2'd0;
    localparam logic [1:0] MODE_IMMED  = 2'd1;
    localparam logic [1:0] MODE_INDIR  = 2'd2;
    localparam logic [1:0] MODE_LEGACY = 2'd3;

    localparam logic [1:0] REL_DIRECT = 2'd0;
    localparam logic [1:0] REL_PC     = 2'd1;
    localparam logic [1:0] REL_BASE   = 2'd2;

    localparam logic [1:0] NI_SIC    = 2'b00;
    localparam logic [1:0] NI_IMMED  = 2'b01;
    localparam logic [1:0] NI_INDIR  = 2'b10;
    localparam logic [1:0] NI_SIMPLE = 2'b11;

    localparam logic [1:0] BP_PC   = 2'b01;
    localparam logic [1:0] BP_BASE = 2'b10;

    localparam logic [2:0] OP_FMT [TABLE_SIZE] = '{
        3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3,
        3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd1, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd1, 3'd3, 3'd2, 3'd3
    };

    typedef struct packed {
        logic [7:0]             obj_byte;
        logic                   record_start;
        logic [PORT_ADDR_W-1:0] record_address;
    } t_in_item;

    typedef struct packed {
        logic [PORT_ADDR_W-1:0] instr_address;
        logic [7:0]             opcode_value;
        logic [IDX_W-1:0]       mnemonic_index;
        logic                   known_opcode;
        logic [2:0]             instr_format;
        logic [1:0]             operand_mode;
        logic                   indexed;
        logic [1:0]             relative_mode;
        logic [3:0]             reg_first;
        logic [3:0]             reg_second;
        logic [PORT_ADDR_W-1:0] field_value;
        logic [PORT_ADDR_W-1:0] target_address;
    } t_result;

    typedef struct packed {
        logic             known;
        logic [IDX_W-1:0] idx;
        logic [2:0]       fmt;
    } t_op_info;

    function automatic t_op_info op_lookup(input logic [7:0] b);
        t_op_info info;
        info.known = 1'b1;
        info.idx   = '0;
        case (b & OP_MASK)
            8'h18: info.idx = 6'd0;
            8'h58: info.idx = 6'd1;
            8'h90: info.idx = 6'd2;
            8'h40: info.idx = 6'd3;
            8'hB4: info.idx = 6'd4;
            8'h28: info.idx = 6'd5;
            8'h88: info.idx = 6'd6;
            8'hA0: info.idx = 6'd7;
            8'h24: info.idx = 6'd8;
            8'h64: info.idx = 6'd9;
            8'h9C: info.idx = 6'd10;
            8'hC4: info.idx = 6'd11;
            8'hC0: info.idx = 6'd12;
            8'hF4: info.idx = 6'd13;
            8'h3C: info.idx = 6'd14;
            8'h30: info.idx = 6'd15;
            8'h34: info.idx = 6'd16;
            8'h38: info.idx = 6'd17;
            8'h48: info.idx = 6'd18;
            8'h00: info.idx = 6'd19;
            8'h68: info.idx = 6'd20;
            8'h50: info.idx = 6'd21;
            8'h70: info.idx = 6'd22;
            8'h08: info.idx = 6'd23;
            8'h6C: info.idx = 6'd24;
            8'h74: info.idx = 6'd25;
            8'h04: info.idx = 6'd26;
            8'hD0: info.idx = 6'd27;
            8'h20: info.idx = 6'd28;
            8'h60: info.idx = 6'd29;
            8'h98: info.idx = 6'd30;
            8'hC8: info.idx = 6'd31;
            8'h44: info.idx = 6'd32;
            8'hD8: info.idx = 6'd33;
            8'hAC: info.idx = 6'd34;
            8'h4C: info.idx = 6'd35;
            8'hA4: info.idx = 6'd36;
            8'hA8: info.idx = 6'd37;
            8'hF0: info.idx = 6'd38;
            8'hEC: info.idx = 6'd39;
            8'h0C: info.idx = 6'd40;
            8'h78: info.idx = 6'd41;
            8'h54: info.idx = 6'd42;
            8'h80: info.idx = 6'd43;
            8'hD4: info.idx = 6'd44;
            8'h14: info.idx = 6'd45;
            8'h7C: info.idx = 6'd46;
            8'hE8: info.idx = 6'd47;
            8'h84: info.idx = 6'd48;
            8'h10: info.idx = 6'd49;
            8'h1C: info.idx = 6'd50;
            8'h5C: info.idx = 6'd51;
            8'h94: info.idx = 6'd52;
            8'hB0: info.idx = 6'd53;
            8'hE0: info.idx = 6'd54;
            8'hF8: info.idx = 6'd55;
            8'h2C: info.idx = 6'd56;
            8'hB8: info.idx = 6'd57;
            8'hDC: info.idx = 6'd58;
            default: info.known = 1'b0;
        endcase
        info.fmt = OP_FMT[info.idx];
        // formats 1 and 2 carry no ni bits
        if (info.known && info.fmt != FMT_3 && b[1:0] != 2'b00) begin
            info.known = 1'b0;
        end
        if (!info.known) begin
            info.idx = '0;
            info.fmt = FMT_1;
        end
        return info;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sicxe_instruction_decoder.sv -----
// sic/xe object-code decoder: one byte word in, one decoded instruction word out
//
// s_axis takes one object-code byte per word; tuser flags the first byte of a
// text record, whose load address rides in tdata and reloads the program counter.
// a partly gathered instruction is dropped when a new record starts.
// m_axis gives one word per finished instruction, or one per unknown opcode byte
// (tuser low, format 1). bytes inside an instruction give no output word.
// path: an accepted byte passes the input register, then one decode pass, then
// the result register that drives m_axis. throughput: one byte per cycle while
// m_axis does not stall, set by the input and result registers. when m_axis
// stalls the result register holds and an empty input register still takes one
// byte; s_axis_tready then drops until the result is taken.
// reset clears the program counter, instruction start, byte count, base register
// and both valid flags; the block is ready on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "sicxe_instruction_decoder_defines.svh"

module sicxe_instruction_decoder
    import sxd_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // obj_byte [7:0], record_address [27:8], zero pad [31:28]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // record_start
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // instr_address [19:0], opcode_value [27:20], mnemonic_index [33:28],
    // instr_format [36:34], operand_mode [38:37], indexed [39],
    // relative_mode [41:40], reg_first [45:42], reg_second [49:46],
    // field_value [69:50], target_address [89:70], zero pad [95:90]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // known_opcode
    output logic                   m_axis_tuser
);

    t_in_item in_item;
    t_in_item stage_item;
    logic     stage_valid;
    logic     out_space;
    logic     advance;
    logic     has_result;
    t_result  dec_result;
    t_result  out_result;

    assign in_item.obj_byte       = s_axis_tdata[7:0];
    assign in_item.record_start   = s_axis_tuser;
    assign in_item.record_address = s_axis_tdata[27:8];

    assign advance = stage_valid && out_space;

    sxd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (s_axis_tready),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    sxd_decode #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (stage_item),
        .o_has_result (has_result),
        .o_result     (dec_result)
    );

    sxd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (dec_result),
        .i_tready (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result),
        .o_space  (out_space)
    );

    assign m_axis_tuser = out_result.known_opcode;
    assign m_axis_tdata = {
        6'd0,
        out_result.target_address,
        out_result.field_value,
        out_result.reg_second,
        out_result.reg_first,
        out_result.relative_mode,
        out_result.indexed,
        out_result.operand_mode,
        out_result.instr_format,
        out_result.mnemonic_index,
        out_result.opcode_value,
        out_result.instr_address
    };

    // extended format is always a known, non-legacy, direct instruction
    `SXD_ASSERT_IMPLY(a_fmt4_direct, i_clk, i_rst_n,
        m_axis_tvalid && out_result.instr_format == FMT_4,
        out_result.known_opcode && out_result.operand_mode != MODE_LEGACY
            && out_result.relative_mode == REL_DIRECT,
        "format 4 result with bad flags")

    // unknown opcode gives a bare one-byte word
    `SXD_ASSERT_IMPLY(a_unknown_bare, i_clk, i_rst_n,
        m_axis_tvalid && !out_result.known_opcode,
        out_result.instr_format == FMT_1 && out_result.mnemonic_index == '0
            && out_result.field_value == '0 && out_result.target_address == '0,
        "unknown opcode word not cleared")

    // relative addressing only in format 3 with n or i set
    `SXD_ASSERT_IMPLY(a_rel_fmt3, i_clk, i_rst_n,
        m_axis_tvalid && out_result.relative_mode != REL_DIRECT,
        out_result.instr_format == FMT_3 && out_result.operand_mode != MODE_LEGACY,
        "relative mode outside format 3")

    // a byte parked in the input register is not lost while the output stalls
    `SXD_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n,
        stage_valid && m_axis_tvalid && !m_axis_tready,
        stage_valid,
        "input stage dropped a byte during stall")

endmodule

`default_nettype wire

// ----- hdl/sxd_in_stage.sv -----
// input register stage of the sic/xe decoder
`timescale 1ns / 1ps
`default_nettype none

module sxd_in_stage
    import sxd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_ready,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sxd_decode.sv -----
// byte gathering state and single-pass decode of sic/xe instructions
`timescale 1ns / 1ps
`default_nettype none

module sxd_decode
    import sxd_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_in_item i_item,
    output logic     o_has_result,
    output t_result  o_result
);

    logic [ADDR_WIDTH-1:0] r_pc;
    logic [ADDR_WIDTH-1:0] r_istart;
    logic [ADDR_WIDTH-1:0] r_base;
    logic [2:0]            r_count;
    logic [7:0]            r_bytes [0:3];

    logic [ADDR_WIDTH-1:0] pc_cur;
    logic [ADDR_WIDTH-1:0] n_pc;
    logic [ADDR_WIDTH-1:0] n_istart;
    logic [ADDR_WIDTH-1:0] n_base;
    logic [2:0]            cnt_cur;
    logic [2:0]            cnt_new;
    logic [2:0]            n_count;
    logic [7:0]            g_bytes [0:3];
    t_op_info              info;
    logic [1:0]            ni;
    logic [2:0]            need;
    logic [19:0]           field;
    logic [ADDR_WIDTH-1:0] disp_sx;
    logic [ADDR_WIDTH-1:0] target;
    logic [1:0]            rel;
    logic [1:0]            mode;
    logic                  load_base;

    always_comb begin
        pc_cur   = i_item.record_start ? ADDR_WIDTH'(i_item.record_address) : r_pc;
        cnt_cur  = i_item.record_start ? 3'd0 : r_count;
        n_istart = (cnt_cur == 3'd0) ? pc_cur : r_istart;
        n_pc     = pc_cur + ADDR_WIDTH'(1);
        cnt_new  = cnt_cur + 3'd1;
        for (int k = 0; k < 4; k++) begin
            g_bytes[k] = (cnt_cur[1:0] == 2'(k)) ? i_item.obj_byte : r_bytes[k];
        end
    end

    always_comb begin
        info = op_lookup(g_bytes[0]);
        ni   = g_bytes[0][1:0];
        need = info.fmt;
        // e bit only seen once the second byte is in
        if (info.fmt == FMT_3 && ni != NI_SIC && cnt_new >= 3'd2 && g_bytes[1][4]) begin
            need = FMT_4;
        end
        o_has_result = !info.known || (cnt_new >= need);
    end

    always_comb begin
        disp_sx = {{(ADDR_WIDTH-12){g_bytes[1][3]}}, g_bytes[1][3:0], g_bytes[2]};
        rel     = REL_DIRECT;
        if (ni == NI_SIC) begin
            field  = {5'd0, g_bytes[1][6:0], g_bytes[2]};
            target = ADDR_WIDTH'(field);
        end else if (need == FMT_4) begin
            field  = {g_bytes[1][3:0], g_bytes[2], g_bytes[3]};
            target = ADDR_WIDTH'(field);
        end else begin
            field = {8'd0, g_bytes[1][3:0], g_bytes[2]};
            case (g_bytes[1][6:5])
                BP_PC: begin
                    target = n_pc + disp_sx;
                    rel    = REL_PC;
                end
                BP_BASE: begin
                    target = r_base + ADDR_WIDTH'(field);
                    rel    = REL_BASE;
                end
                default: begin
                    target = ADDR_WIDTH'(field);
                end
            endcase
        end
        case (ni)
            NI_SIMPLE: mode = MODE_SIMPLE;
            NI_IMMED:  mode = MODE_IMMED;
            NI_INDIR:  mode = MODE_INDIR;
            default:   mode = MODE_LEGACY;
        endcase
    end

    always_comb begin
        o_result                = '0;
        o_result.instr_address  = PORT_ADDR_W'(n_istart);
        o_result.opcode_value   = g_bytes[0];
        o_result.instr_format   = FMT_1;
        o_result.known_opcode   = info.known;
        o_result.mnemonic_index = info.idx;
        load_base               = 1'b0;
        if (info.known) begin
            o_result.instr_format = need;
            if (need == FMT_2) begin
                o_result.reg_first  = g_bytes[1][7:4];
                o_result.reg_second = g_bytes[1][3:0];
            end else if (need == FMT_3 || need == FMT_4) begin
                o_result.opcode_value   = g_bytes[0] & OP_MASK;
                o_result.operand_mode   = mode;
                o_result.indexed        = g_bytes[1][7];
                o_result.relative_mode  = rel;
                o_result.field_value    = field;
                o_result.target_address = PORT_ADDR_W'(target);
                load_base               = ((g_bytes[0] & OP_MASK) == OP_LDB);
            end
        end
        n_count = o_has_result ? 3'd0 : cnt_new;
        n_base  = (o_has_result && load_base) ? target : r_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_istart <= '0;
            r_base   <= '0;
            r_count  <= '0;
        end else if (i_advance) begin
            r_pc     <= n_pc;
            r_istart <= n_istart;
            r_base   <= n_base;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_bytes[cnt_cur[1:0]] <= i_item.obj_byte;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sxd_out_stage.sv -----
// result register of the sic/xe decoder
`timescale 1ns / 1ps
`default_nettype none

module sxd_out_stage
    import sxd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_tready,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_space
);

    logic    r_valid;
    t_result r_result;

    assign o_space  = !r_valid || i_tready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire
